### design/can_message_segmenter_defines.svh
// Assertion macros for the CAN message segmenter.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef CAN_MESSAGE_SEGMENTER_DEFINES_SVH
`define CAN_MESSAGE_SEGMENTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CMS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CMS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CMS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/cms_pkg.sv
// Shared types and constants of the CAN message segmenter.
// No dependencies; used by every module of the block.
package cms_pkg;

   localparam int FRAME_BYTES  = 8;
   localparam int PAYLOAD_BYTES = 8;
   localparam int BYTE_W       = 8;
   localparam int PAYLOAD_W    = PAYLOAD_BYTES * BYTE_W;
   localparam int POS_W        = $clog2(FRAME_BYTES + 1);
   localparam int COUNT_W      = 8;
   localparam int TYPE_W       = 4;
   localparam int NODE_W       = 4;
   localparam int CODE_W       = 3;
   localparam int ID_W         = TYPE_W + NODE_W + CODE_W;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 8;
   localparam int FIFO_DEPTH   = 2;
   localparam int FIFO_PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

   localparam logic [CODE_W-1:0] FIRST_CODE_RESET = CODE_W'(0);
   localparam logic [CODE_W-1:0] END_CODE_RESET   = CODE_W'(7);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENDER_ID        = 3'd0,
      CSR_MESSAGE_TYPE     = 3'd1,
      CSR_TARGET_NODE      = 3'd2,
      CSR_FIRST_FRAME_CODE = 3'd3,
      CSR_END_FRAME_CODE   = 3'd4,
      CSR_FILL_BYTE        = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] message_length;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]      frame_id;
      logic [PAYLOAD_W-1:0] frame_payload;
      logic                 last_frame;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sender_id;
      logic [TYPE_W-1:0] message_type;
      logic [NODE_W-1:0] target_node;
      logic [CODE_W-1:0] first_frame_code;
      logic [CODE_W-1:0] end_frame_code;
      logic [BYTE_W-1:0] fill_byte;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] message_length;
      logic [POS_W-1:0]  pos;
      logic              start;
      logic              last;
      logic              emit;
   } cmd_type;

endpackage

### design/cms_front.sv
// Front end of the CAN message segmenter: tracks message and frame fill,
// turns each accepted byte into a packing command. Depends on cms_pkg.
module cms_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  cms_pkg::req_type req_data,
   input  logic             cmd_full,
   output logic             cmd_push,
   output cms_pkg::cmd_type cmd_data
);

   logic [cms_pkg::COUNT_W-1:0] count_ff, count_in, count_inc;
   logic [cms_pkg::POS_W-1:0]   fill_ff, fill_in, pos;
   logic                        start, last, emit;

   assign cmd_push  = req_push && !cmd_full;
   assign start     = (count_ff == '0);
   assign pos       = start ? cms_pkg::POS_W'(2) : fill_ff;
   assign count_inc = count_ff + cms_pkg::COUNT_W'(1);
   assign last      = (count_inc == req_data.message_length);
   assign emit      = last || (pos == cms_pkg::POS_W'(cms_pkg::FRAME_BYTES - 1));

   always_comb begin
      count_in = count_ff;
      fill_in  = fill_ff;
      if (cmd_push) begin
         count_in = last ? '0 : count_inc;
         fill_in  = emit ? cms_pkg::POS_W'(1) : pos + cms_pkg::POS_W'(1);
      end
   end

   always_comb begin
      cmd_data.data_byte      = req_data.data_byte;
      cmd_data.message_length = req_data.message_length;
      cmd_data.pos            = pos;
      cmd_data.start          = start;
      cmd_data.last           = last;
      cmd_data.emit           = emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= '0;
      end else begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

### design/cms_cmd_fifo.sv
// Short command queue between front and back of the segmenter.
// Depends on cms_pkg for the command type and depth.
module cms_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cms_pkg::cmd_type push_data,
   input  logic             pop,
   output cms_pkg::cmd_type pop_data,
   output logic             full,
   output logic             empty
);

   cms_pkg::cmd_type                 entry_ff [cms_pkg::FIFO_DEPTH];
   logic [cms_pkg::FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [cms_pkg::FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                             do_push, do_pop;

   assign full     = (count_ff == cms_pkg::FIFO_CNT_W'(cms_pkg::FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == cms_pkg::FIFO_PTR_W'(cms_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + cms_pkg::FIFO_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == cms_pkg::FIFO_PTR_W'(cms_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + cms_pkg::FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + cms_pkg::FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - cms_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/cms_back.sv
// Back end of the segmenter: packs bytes into the frame buffer, pads and
// issues finished frames through an output register. Depends on cms_pkg.
module cms_back (
   input  logic             clock,
   input  logic             reset,
   input  cms_pkg::cfg_type cfg,
   input  logic             cmd_empty,
   input  cms_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_pop,
   output cms_pkg::rsp_type rsp_data
);

   logic [cms_pkg::PAYLOAD_W-1:0] buffer_ff, buffer_in, packed_buf, padded;
   logic [cms_pkg::CODE_W-1:0]    code_ff, code_in, code_cur;
   logic                          valid_ff, valid_in, out_ready, load;
   cms_pkg::rsp_type              rsp_ff, rsp_in;

   assign out_ready = !valid_ff || rsp_pop;
   assign cmd_pop   = !cmd_empty && (!cmd_data.emit || out_ready);
   assign load      = cmd_pop && cmd_data.emit;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      packed_buf = buffer_ff;
      code_cur   = code_ff;
      if (cmd_data.start) begin
         packed_buf = '0;
         packed_buf[0 +: cms_pkg::BYTE_W] = cfg.sender_id;
         packed_buf[cms_pkg::BYTE_W +: cms_pkg::BYTE_W] = cmd_data.message_length;
         code_cur = cfg.first_frame_code;
      end
      for (int k = 0; k < cms_pkg::FRAME_BYTES; k++) begin
         if (cms_pkg::POS_W'(k) == cmd_data.pos) begin
            packed_buf[k*cms_pkg::BYTE_W +: cms_pkg::BYTE_W] = cmd_data.data_byte;
         end
      end
      padded = packed_buf;
      for (int k = 0; k < cms_pkg::FRAME_BYTES; k++) begin
         if (cms_pkg::POS_W'(k) > cmd_data.pos) begin
            padded[k*cms_pkg::BYTE_W +: cms_pkg::BYTE_W] = cfg.fill_byte;
         end
      end
   end

   always_comb begin
      buffer_in = buffer_ff;
      code_in   = code_ff;
      valid_in  = valid_ff && !rsp_pop;
      rsp_in    = rsp_ff;
      if (cmd_pop) begin
         buffer_in = packed_buf;
         code_in   = code_cur;
      end
      if (load) begin
         buffer_in = '0;
         buffer_in[0 +: cms_pkg::BYTE_W] = cfg.sender_id;
         code_in   = code_cur + cms_pkg::CODE_W'(1);
         valid_in  = 1'b1;
         rsp_in.frame_id      = {cfg.message_type, cfg.target_node,
                                 cmd_data.last ? cfg.end_frame_code : code_cur};
         rsp_in.frame_payload = padded;
         rsp_in.last_frame    = cmd_data.last;
      end
   end

   always_ff @(posedge clock) begin
      buffer_ff <= buffer_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff  <= cms_pkg::FIRST_CODE_RESET;
         valid_ff <= 1'b0;
      end else begin
         code_ff  <= code_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### design/can_message_segmenter.sv
// Top level of the CAN message segmenter: register file, front end,
// command queue and back end. Depends on cms_pkg and the defines header.
//
// Takes one message byte per cycle while req_full is low and delivers one CAN
// frame per cycle at most. The frame that a byte completes passes through the
// command queue and the output register of the back end before it sits on the
// result ports. The rate is set by the packing step of the back end, fed
// through a two-entry command queue; full rises only while the back end
// is held by a result not yet popped. Register writes land at the next clock edge.
`include "can_message_segmenter_defines.svh"
module can_message_segmenter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  cms_pkg::req_type                  req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output cms_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write,
   input  logic [cms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cms_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   cms_pkg::cfg_type cfg_ff, cfg_in;
   cms_pkg::cmd_type cmd_push_data, cmd_q;
   logic             cmd_push, cmd_pop, cmd_full, cmd_empty, rsp_valid;

   assign req_full  = cmd_full;
   assign rsp_empty = !rsp_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            cms_pkg::CSR_SENDER_ID: begin
               cfg_in.sender_id = csr_wdata;
            end
            cms_pkg::CSR_MESSAGE_TYPE: begin
               cfg_in.message_type = csr_wdata[cms_pkg::TYPE_W-1:0];
            end
            cms_pkg::CSR_TARGET_NODE: begin
               cfg_in.target_node = csr_wdata[cms_pkg::NODE_W-1:0];
            end
            cms_pkg::CSR_FIRST_FRAME_CODE: begin
               cfg_in.first_frame_code = csr_wdata[cms_pkg::CODE_W-1:0];
            end
            cms_pkg::CSR_END_FRAME_CODE: begin
               cfg_in.end_frame_code = csr_wdata[cms_pkg::CODE_W-1:0];
            end
            cms_pkg::CSR_FILL_BYTE: begin
               cfg_in.fill_byte = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sender_id        <= '0;
         cfg_ff.message_type     <= '0;
         cfg_ff.target_node      <= '0;
         cfg_ff.first_frame_code <= cms_pkg::FIRST_CODE_RESET;
         cfg_ff.end_frame_code   <= cms_pkg::END_CODE_RESET;
         cfg_ff.fill_byte        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cms_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_push_data)
   );

   cms_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .pop       (cmd_pop),
      .pop_data  (cmd_q),
      .full      (cmd_full),
      .empty     (cmd_empty)
   );

   cms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_q),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   `CMS_ASSERT_IMPLY(a_pop_needs_cmd, clock, reset, cmd_pop, !cmd_empty)
   `CMS_ASSERT_NEXT(a_no_spurious_frame, clock, reset,
      rsp_empty && !(cmd_pop && cmd_q.emit), rsp_empty)
   `CMS_ASSERT_IMPLY(a_last_uses_end_code, clock, reset,
      !rsp_empty && rsp_data.last_frame,
      rsp_data.frame_id[cms_pkg::CODE_W-1:0] == cfg_ff.end_frame_code)

endmodule

### dv/can_message_segmenter_test.sv
// Self-checking testbench for can_message_segmenter: drives message bytes, mirrors the
// frame packing in a local predictor and checks every frame popped from the block.
// Depends on cms_pkg and the can_message_segmenter RTL.
module can_message_segmenter_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PER_PHASE = 30;
   localparam logic [cms_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [cms_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   cms_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   cms_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [cms_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cms_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   cms_pkg::req_type bytes_waiting[$];
   cms_pkg::rsp_type frames_due[$];
   int requests_open = 0;
   int requests_queued = 0;
   int mismatches = 0;
   int cycle_count = 0;

   // predictor state
   cms_pkg::cfg_type cfg_mirror;
   logic [7:0] msg_count;
   int fill_pos;
   logic [cms_pkg::PAYLOAD_W-1:0] frame_buf;
   logic [cms_pkg::CODE_W-1:0] frame_code;

   // generator's view of the message count, to start messages cleanly
   logic [7:0] gen_count = '0;

   can_message_segmenter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit take_break();
      return (cycle_count % 4096 >= 1536) && ($urandom_range(0, 99) < 15);
   endfunction

   task automatic pack_byte(input cms_pkg::req_type r);
      logic last;
      cms_pkg::rsp_type f;
      if (msg_count == 0) begin
         frame_buf = '0;
         frame_code = cfg_mirror.first_frame_code;
         frame_buf[7:0] = cfg_mirror.sender_id;
         frame_buf[15:8] = r.message_length;
         fill_pos = 2;
      end
      frame_buf[fill_pos*8 +: 8] = r.data_byte;
      fill_pos++;
      msg_count++;
      last = (msg_count == r.message_length);
      if (fill_pos < cms_pkg::FRAME_BYTES && !last) return;
      while (fill_pos < cms_pkg::FRAME_BYTES) begin
         frame_buf[fill_pos*8 +: 8] = cfg_mirror.fill_byte;
         fill_pos++;
      end
      f.frame_id = {cfg_mirror.message_type, cfg_mirror.target_node,
                    last ? cfg_mirror.end_frame_code : frame_code};
      f.frame_payload = frame_buf;
      f.last_frame = last;
      frames_due.push_back(f);
      frame_buf = '0;
      frame_buf[7:0] = cfg_mirror.sender_id;
      fill_pos = 1;
      frame_code++;
      if (last) msg_count = '0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            pack_byte(req_data);
            requests_open--;
         end
         if (req_push && req_full) begin
            // hold the request until taken
         end else if (bytes_waiting.size() != 0 && !take_break()) begin
            req_push <= 1'b1;
            req_data <= bytes_waiting.pop_front();
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cms_pkg::rsp_type f;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (frames_due.size() == 0) begin
               $error("unexpected frame: id %h payload %h", rsp_data.frame_id,
                      rsp_data.frame_payload);
               mismatches++;
            end else begin
               f = frames_due.pop_front();
               if (rsp_data.frame_id !== f.frame_id) begin
                  $error("frame_id: expected %h, got %h", f.frame_id, rsp_data.frame_id);
                  mismatches++;
               end
               if (rsp_data.frame_payload !== f.frame_payload) begin
                  $error("frame_payload: expected %h, got %h", f.frame_payload,
                         rsp_data.frame_payload);
                  mismatches++;
               end
               if (rsp_data.last_frame !== f.last_frame) begin
                  $error("last_frame: expected %b, got %b", f.last_frame,
                         rsp_data.last_frame);
                  mismatches++;
               end
            end
         end
         rsp_pop <= !take_break();
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("can_message_segmenter_test failed");
         $finish;
      end else begin
         cycle_count++;
      end
   end

   task automatic add_request(input logic [7:0] data, input logic [7:0] len);
      cms_pkg::req_type r;
      r.data_byte = data;
      r.message_length = len;
      gen_count++;
      if (gen_count == len) gen_count = '0;
      requests_open++;
      requests_queued++;
      bytes_waiting.push_back(r);
   endtask

   // close any open message, then send one of len bytes (zero means 256)
   task automatic add_message(input logic [7:0] len);
      int n;
      if (gen_count != 0) add_request(8'($urandom), gen_count + 8'd1);
      n = (len == 0) ? 256 : len;
      for (int i = 0; i < n; i++) add_request(8'($urandom), len);
   endtask

   task automatic write_reg(input logic [cms_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         cms_pkg::CSR_SENDER_ID:        cfg_mirror.sender_id = val;
         cms_pkg::CSR_MESSAGE_TYPE:     cfg_mirror.message_type = val[3:0];
         cms_pkg::CSR_TARGET_NODE:      cfg_mirror.target_node = val[3:0];
         cms_pkg::CSR_FIRST_FRAME_CODE: cfg_mirror.first_frame_code = val[2:0];
         cms_pkg::CSR_END_FRAME_CODE:   cfg_mirror.end_frame_code = val[2:0];
         cms_pkg::CSR_FILL_BYTE:        cfg_mirror.fill_byte = val;
         default: ;
      endcase
   endtask

   task automatic wait_quiet();
      while (requests_open != 0 || frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int start;
      int pick;
      cfg_mirror = '0;
      cfg_mirror.first_frame_code = cms_pkg::FIRST_CODE_RESET;
      cfg_mirror.end_frame_code = cms_pkg::END_CODE_RESET;
      msg_count = '0;
      fill_pos = 0;
      frame_buf = '0;
      frame_code = cms_pkg::FIRST_CODE_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset register values, short directed messages
      add_message(8'd1);
      add_request(8'hFF, 8'd2);
      add_request(8'h00, 8'd2);
      add_request(8'h00, 8'd6);
      for (int i = 0; i < 4; i++) add_request(8'($urandom), 8'd6);
      add_request(8'hFF, 8'd6);
      add_message(8'd7);
      add_request(8'hA5, 8'd3);
      add_request(8'h5A, 8'd2);
      wait_quiet();

      for (int phase = 1; phase < 8; phase++) begin
         if (phase == 1) begin
            write_reg(cms_pkg::CSR_SENDER_ID, 8'hFF);
            write_reg(cms_pkg::CSR_MESSAGE_TYPE, 8'hFF);
            write_reg(cms_pkg::CSR_TARGET_NODE, 8'hFF);
            write_reg(cms_pkg::CSR_FIRST_FRAME_CODE, 8'hFF);
            write_reg(cms_pkg::CSR_END_FRAME_CODE, 8'h00);
            write_reg(cms_pkg::CSR_FILL_BYTE, 8'hFF);
            write_reg(CSR_SPARE_A, 8'($urandom));
            write_reg(CSR_SPARE_B, 8'($urandom));
         end else if (phase == 2) begin
            write_reg(cms_pkg::CSR_SENDER_ID, 8'h00);
            write_reg(cms_pkg::CSR_MESSAGE_TYPE, 8'h00);
            write_reg(cms_pkg::CSR_TARGET_NODE, 8'h00);
            write_reg(cms_pkg::CSR_FIRST_FRAME_CODE, 8'h00);
            write_reg(cms_pkg::CSR_END_FRAME_CODE, 8'h07);
            write_reg(cms_pkg::CSR_FILL_BYTE, 8'h00);
         end else begin
            if ($urandom_range(0, 1)) write_reg(cms_pkg::CSR_SENDER_ID, 8'($urandom));
            if ($urandom_range(0, 1)) write_reg(cms_pkg::CSR_MESSAGE_TYPE, 8'($urandom));
            if ($urandom_range(0, 1)) write_reg(cms_pkg::CSR_TARGET_NODE, 8'($urandom));
            if ($urandom_range(0, 1)) begin
               write_reg(cms_pkg::CSR_FIRST_FRAME_CODE, 8'($urandom));
            end
            if ($urandom_range(0, 1)) write_reg(cms_pkg::CSR_END_FRAME_CODE, 8'($urandom));
            if ($urandom_range(0, 1)) write_reg(cms_pkg::CSR_FILL_BYTE, 8'($urandom));
            if ($urandom_range(0, 3) == 0) write_reg(CSR_SPARE_A, 8'($urandom));
         end
         @(posedge clock);
         csr_write <= 1'b0;

         if (phase == 1) add_message(8'd255);
         if (phase == 2) add_message(8'd0);
         start = requests_queued;
         while (requests_queued - start < RANDOM_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               pick = $urandom_range(0, 99);
               if (pick < 70) add_message(8'($urandom_range(1, 20)));
               else if (pick < 96) add_message(8'($urandom_range(21, 64)));
               else add_message(8'($urandom_range(65, 255)));
            end else begin
               add_request(8'($urandom), 8'($urandom));
            end
         end
         wait_quiet();
      end

      if (mismatches == 0) begin
         $display("can_message_segmenter_test passed");
      end else begin
         $display("can_message_segmenter_test failed");
      end
      $finish;
   end

endmodule
